>>> hw/rtl/sha256_message_digest_defines.svh
// ----------------------------------------------------------------------------
// SHA-256 message digest: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication
`define SMD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/s256md_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest package
// Word and control types, round constants, initial hash and sigma functions.
// ----------------------------------------------------------------------------
package s256md_pkg;

   typedef logic [31:0] word_type;

   // control from the sequencer to the message schedule
   typedef struct packed {
      logic shift;    // advance window one round
      logic byte_we;  // write one message byte
      logic pad;      // write 0x80 marker and zero fill
      logic clear;    // zero the block (words 14/15 kept when len_we is set)
      logic len_we;   // write 64-bit bit length into words 14/15
   } sched_ctl_type;

   // control from the sequencer to the round unit
   typedef struct packed {
      logic init;     // reload initial hash
      logic start;    // load working vars from chaining value
      logic run;      // execute one round
      logic add;      // fold working vars into chaining value
   } round_ctl_type;

   localparam int unsigned ROUNDS = 64;
   localparam logic [5:0]  LAST_ROUND = 6'(ROUNDS - 1);
   localparam logic [5:0]  LAST_BYTE = 6'd63;
   localparam logic [5:0]  LEN_POS = 6'd56;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   localparam word_type ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type IV_WORDS [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // schedule sigmas
   function automatic word_type small_sigma0(word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // round sigmas
   function automatic word_type big_sigma0(word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

endpackage

>>> hw/rtl/s256md_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word block buffer that doubles as the schedule window: bytes and
// padding are written in place, then it shifts one word per round.
// ----------------------------------------------------------------------------
module s256md_sched (
   input  logic                     clock,
   input  s256md_pkg::sched_ctl_type ctl,
   input  logic [5:0]               pos,
   input  logic [7:0]               data,
   input  logic [63:0]              bit_len,
   output s256md_pkg::word_type     w_t
);

   s256md_pkg::word_type w_ff [0:15];
   s256md_pkg::word_type w_new;

   // W[t+16] from the current window
   assign w_new = w_ff[0] + s256md_pkg::small_sigma0(w_ff[1]) + w_ff[9]
                  + s256md_pkg::small_sigma1(w_ff[14]);

   assign w_t = w_ff[0];

   // window updates
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= w_new;
      end else begin
         if (ctl.byte_we) begin
            for (int j = 0; j < 4; j++) begin
               if (pos[1:0] == 2'(j)) begin
                  w_ff[pos[5:2]][(3 - j) * 8 +: 8] <= data;
               end
            end
         end
         // words 14/15 are left to the length write when it comes in the same cycle
         if (ctl.clear) begin
            for (int i = 0; i < 16; i++) begin
               if (!(ctl.len_we && i >= 14)) begin
                  w_ff[i] <= '0;
               end
            end
         end
         // marker at pos, zeros above it
         if (ctl.pad) begin
            for (int i = 0; i < 16; i++) begin
               if (!(ctl.len_we && i >= 14)) begin
                  for (int j = 0; j < 4; j++) begin
                     if (6'(4 * i + j) == pos) begin
                        w_ff[i][(3 - j) * 8 +: 8] <= s256md_pkg::PAD_BYTE;
                     end else if (6'(4 * i + j) > pos) begin
                        w_ff[i][(3 - j) * 8 +: 8] <= 8'h00;
                     end
                  end
               end
            end
         end
         if (ctl.len_we) begin
            w_ff[14] <= bit_len[63:32];
            w_ff[15] <= bit_len[31:0];
         end
      end
   end

endmodule

>>> hw/rtl/s256md_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables a..h with one compression round per cycle while run is
// set, and the eight-word chaining value that each block is folded into.
// ----------------------------------------------------------------------------
module s256md_round (
   input  logic                     clock,
   input  logic                     reset,
   input  s256md_pkg::round_ctl_type ctl,
   input  logic [5:0]               rnd,
   input  s256md_pkg::word_type     w_t,
   input  logic [2:0]               rd_idx,
   output s256md_pkg::word_type     chain_word
);

   s256md_pkg::word_type v_ff [0:7];
   s256md_pkg::word_type h_ff [0:7];
   s256md_pkg::word_type t1;
   s256md_pkg::word_type t2;
   s256md_pkg::word_type ch;
   s256md_pkg::word_type maj;

   // round function
   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + s256md_pkg::big_sigma1(v_ff[4]) + ch
                + s256md_pkg::ROUND_K[rnd] + w_t;
   assign t2  = s256md_pkg::big_sigma0(v_ff[0]) + maj;

   assign chain_word = h_ff[rd_idx];

   // working variables
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= h_ff[i];
         end
      end else if (ctl.run) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   // chaining value
   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= s256md_pkg::IV_WORDS[i];
         end
      end else if (ctl.add) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= h_ff[i] + v_ff[i];
         end
      end
   end

endmodule

>>> hw/rtl/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest, top level
// Byte-wide message input, sequencer, padding control and digest output.
// ----------------------------------------------------------------------------
// A message enters one byte per item; req_last_item marks its end, and an item
// with req_byte_valid low and req_last_item high ends it without a byte (this
// hashes the empty message). req_ready stays high after a byte, except after
// the 64th byte of each block, when the single round unit runs 64 rounds
// (ST_ROUND) and folds the block in (ST_ADD) before req_ready returns. The end
// item passes ST_PAD and then one compression, or two with ST_LEN setting up
// the length block if 56 or more bytes sit in the last block; an end item that
// fills a block first runs that block's compression. The eight digest words
// then leave on rsp_*, word 0 first, rsp_last_word on word 7, one per cycle at
// best; the block takes no new item until the last word is taken.
module sha256_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_LEN   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;
   localparam logic [2:0] LAST_IDX = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  nxt_ff, nxt_in;      // state after the running compression
   logic [5:0]  rnd_ff, rnd_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] count_ff, count_in;
   logic [2:0]  widx_ff, widx_in;
   logic        accept;

   s256md_pkg::sched_ctl_type sctl;
   s256md_pkg::round_ctl_type rctl;
   s256md_pkg::word_type      w_t;
   s256md_pkg::word_type      chain_word;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain_word;
   assign rsp_word_index  = widx_ff;
   assign rsp_last_word   = (widx_ff == LAST_IDX);

   // sequencer
   always_comb begin
      state_in = state_ff;
      nxt_in   = nxt_ff;
      rnd_in   = rnd_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      widx_in  = widx_ff;
      sctl     = '0;
      rctl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_byte_valid) begin
                  sctl.byte_we = 1'b1;
                  count_in     = count_ff + s256md_pkg::BITS_PER_BYTE;
                  pos_in       = pos_ff + 6'd1;
                  if (pos_ff == s256md_pkg::LAST_BYTE) begin
                     // block full: compress, then pad if this ends the message
                     rctl.start = 1'b1;
                     rnd_in     = '0;
                     state_in   = ST_ROUND;
                     nxt_in     = req_last_item ? ST_PAD : ST_IDLE;
                  end else if (req_last_item) begin
                     state_in = ST_PAD;
                  end
               end else if (req_last_item) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            sctl.shift = 1'b1;
            rctl.run   = 1'b1;
            rnd_in     = rnd_ff + 6'd1;
            if (rnd_ff == s256md_pkg::LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            rctl.add = 1'b1;
            state_in = nxt_ff;
         end
         ST_PAD: begin
            sctl.pad   = 1'b1;
            rctl.start = 1'b1;
            rnd_in     = '0;
            state_in   = ST_ROUND;
            if (pos_ff >= s256md_pkg::LEN_POS) begin
               // no room for the length: it goes into an extra block
               nxt_in = ST_LEN;
            end else begin
               sctl.len_we = 1'b1;
               nxt_in      = ST_OUT;
            end
         end
         ST_LEN: begin
            sctl.clear  = 1'b1;
            sctl.len_we = 1'b1;
            rctl.start  = 1'b1;
            rnd_in      = '0;
            state_in    = ST_ROUND;
            nxt_in      = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == LAST_IDX) begin
                  rctl.init = 1'b1;
                  pos_in    = '0;
                  count_in  = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nxt_ff   <= ST_IDLE;
         rnd_ff   <= '0;
         pos_ff   <= '0;
         count_ff <= '0;
         widx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         nxt_ff   <= nxt_in;
         rnd_ff   <= rnd_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         widx_ff  <= widx_in;
      end
   end

   s256md_sched u_sched (
      .clock   (clock),
      .ctl     (sctl),
      .pos     (pos_ff),
      .data    (req_data_byte),
      .bit_len (count_ff),
      .w_t     (w_t)
   );

   s256md_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rctl),
      .rnd        (rnd_ff),
      .w_t        (w_t),
      .rd_idx     (widx_ff),
      .chain_word (chain_word)
   );

endmodule

>>> hw/rtl/s256md_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 message digest port checker
// Watches the top-level ports for input/output sequencing and digest order.
// ----------------------------------------------------------------------------
`include "sha256_message_digest_defines.svh"

module s256md_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_item,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_word_index,
   input logic       rsp_last_word
);

   // no new item is taken while digest words are pending
   `SMD_ASSERT_NOW(a_no_input_during_output, rsp_valid, !req_ready, "input open during output")

   // last marker sits on word seven only
   `SMD_ASSERT_NOW(a_last_on_word7, rsp_valid, rsp_last_word == (rsp_word_index == 3'd7), "last word marker misplaced")

   // words leave in order without gaps
   `SMD_ASSERT_NEXT(a_word_order, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1), "digest word out of order")

   // after the final word the block is open for a new message
   `SMD_ASSERT_NEXT(a_ready_after_digest, rsp_valid && rsp_ready && rsp_last_word, req_ready && !rsp_valid, "not ready after digest")

   // an end item always makes the block busy, compressing or padding
   `SMD_ASSERT_NEXT(a_busy_after_end, req_valid && req_ready && req_last_item, !req_ready, "ready right after end item")

endmodule

bind sha256_message_digest s256md_checker u_checker (.*);
